// ===== sv/fflia_pkg.sv =====
`default_nettype none

package fflia_pkg;

    // Width of an index word and of the in-use count.
    localparam int IDX_W  = 11;
    localparam int STAT_W = 2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_HELD = 2'd2;

    typedef struct packed {
        logic             mode;
        logic [IDX_W-1:0] index;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0]  granted_index;
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  in_use_count;
    } t_rsp;

endpackage

`default_nettype wire

// ===== sv/fflia_ram.sv =====
`default_nettype none

// Simple dual-port memory: one write port, one read port with registered data.
module fflia_ram #(
    parameter int WIDTH  = 11,
    parameter int DEPTH  = 1025,
    parameter int ADDR_W = 11
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/fifo_free_list_index_allocator.sv =====
`default_nettype none

// Free-list index allocator. It hands out indices 1..MAX_INDEX in first-in
// first-out order and takes them back on free. A word is accepted on a clock
// edge where start is high and busy is low. Its result word appears on o_rsp
// with o_strobe high for exactly one cycle, and the receiver has to take it
// then, since it cannot stall the block. Busy stays high while a request
// runs: an allocate passes through the execute state, and a free through the
// execute state and, if it appends to a non-empty list, the link state; no
// new word is accepted before the last one is through. This is set by the
// two memories: each request first reads them (the link of the head, or the
// mark of the freed index) and then writes back, and a free that appends at
// the tail needs a second write to the link memory to link the old tail to
// the new entry. The result word is registered at the end of the execute
// state. After reset the block runs a clearing pass over all MAX_INDEX+1
// memory entries, one entry per cycle, and holds busy high until it is done.
// MAX_INDEX must stay below 2048 so that indices fit the 11-bit fields.
module fifo_free_list_index_allocator #(
    parameter int MAX_INDEX = 1024
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire fflia_pkg::t_req i_req,
    output logic                busy,
    output logic                o_strobe,
    output fflia_pkg::t_rsp     o_rsp
);

    localparam int IDX_W  = fflia_pkg::IDX_W;
    localparam int DEPTH  = MAX_INDEX + 1;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IDX_W-1:0]  MAX_IDX  = IDX_W'(MAX_INDEX);
    localparam logic [ADDR_W-1:0] MAX_ADDR = ADDR_W'(MAX_INDEX);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_LINK  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Free-list pointers and the held count.
    logic [IDX_W-1:0]  r_head, n_head;
    logic [IDX_W-1:0]  r_tail, n_tail;
    logic [IDX_W-1:0]  r_count, n_count;
    logic [ADDR_W-1:0] r_clr, n_clr;

    // The request word under execution.
    logic             r_mode;
    logic [IDX_W-1:0] r_idx;

    // Result register.
    logic            r_strobe, n_strobe;
    fflia_pkg::t_rsp r_out, n_out;

    // Memory ports.
    logic              link_we;
    logic [ADDR_W-1:0] link_waddr;
    logic [IDX_W-1:0]  link_wdata;
    logic [IDX_W-1:0]  link_rdata;
    logic              held_we;
    logic [ADDR_W-1:0] held_waddr;
    logic              held_wdata;
    logic              held_rdata;

    logic accept;
    logic head_ok;
    logic free_ok;
    logic list_empty;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // The read addresses are presented in the accept cycle, so the registered
    // data is ready in the execute cycle. Every write of a request completes
    // before the block returns to idle, so a read never overlaps a pending
    // write to the same entry.
    fflia_ram #(
        .WIDTH (IDX_W),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_link_ram (
        .i_clk  (i_clk),
        .i_we   (link_we),
        .i_waddr(link_waddr),
        .i_wdata(link_wdata),
        .i_raddr(r_head[ADDR_W-1:0]),
        .o_rdata(link_rdata)
    );

    fflia_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_held_ram (
        .i_clk  (i_clk),
        .i_we   (held_we),
        .i_waddr(held_waddr),
        .i_wdata(held_wdata),
        .i_raddr(i_req.index[ADDR_W-1:0]),
        .o_rdata(held_rdata)
    );

    // The head can be handed out when the list is not empty.
    assign head_ok = (r_head != '0) && (r_head <= MAX_IDX);

    // A free counts only for a real index that is currently held.
    assign free_ok = (r_idx != '0) && (r_idx <= MAX_IDX) && held_rdata;

    // With no usable tail the freed index starts a fresh list.
    assign list_empty = (r_head == '0) || (r_tail == '0) || (r_tail > MAX_IDX);

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_clr      = r_clr;
        n_strobe   = 1'b0;
        n_out      = r_out;
        link_we    = 1'b0;
        link_waddr = r_idx[ADDR_W-1:0];
        link_wdata = '0;
        held_we    = 1'b0;
        held_waddr = r_idx[ADDR_W-1:0];
        held_wdata = 1'b0;

        case (r_state)
            S_CLEAR: begin
                // Each entry links to its successor; the last one ends the list.
                link_we    = 1'b1;
                link_waddr = r_clr;
                link_wdata = (r_clr == MAX_ADDR) ? '0 : IDX_W'(r_clr) + IDX_W'(1);
                held_we    = 1'b1;
                held_waddr = r_clr;
                held_wdata = 1'b0;
                if (r_clr == MAX_ADDR) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + ADDR_W'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_strobe            = 1'b1;
                n_out.granted_index = '0;
                n_out.status        = fflia_pkg::ST_DONE;
                n_state             = S_IDLE;
                if (r_mode == fflia_pkg::MODE_ALLOC) begin
                    if (head_ok) begin
                        n_out.granted_index = r_head;
                        n_head              = link_rdata;
                        n_count             = r_count + IDX_W'(1);
                        held_we             = 1'b1;
                        held_waddr          = r_head[ADDR_W-1:0];
                        held_wdata          = 1'b1;
                    end else begin
                        n_out.status = fflia_pkg::ST_EMPTY;
                    end
                end else begin
                    if (free_ok) begin
                        held_we    = 1'b1;
                        held_wdata = 1'b0;
                        link_we    = 1'b1;
                        link_wdata = '0;
                        if (r_count != '0) begin
                            n_count = r_count - IDX_W'(1);
                        end
                        if (list_empty) begin
                            n_head = r_idx;
                            n_tail = r_idx;
                        end else begin
                            // The old tail still has to point at the new entry.
                            n_state = S_LINK;
                        end
                    end else begin
                        n_out.status = fflia_pkg::ST_NOT_HELD;
                    end
                end
                n_out.in_use_count = n_count;
            end
            S_LINK: begin
                link_we    = 1'b1;
                link_waddr = r_tail[ADDR_W-1:0];
                link_wdata = r_idx;
                n_tail     = r_idx;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
                n_clr   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_head   <= IDX_W'(1);
            r_tail   <= MAX_IDX;
            r_count  <= '0;
            r_clr    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_clr    <= n_clr;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (accept) begin
            r_mode <= i_req.mode;
            r_idx  <= i_req.index;
        end
    end

    assign o_strobe = r_strobe;
    assign o_rsp    = r_out;

    // A result word follows exactly one execute cycle.
    a_strobe_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_EXEC))
        else $error("result strobe without an executed request");

    // The tail link is written only for a free that was just executed.
    a_link_after_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK) |-> ($past(r_state == S_EXEC) && r_mode == fflia_pkg::MODE_FREE))
        else $error("tail link write outside a free");

    // A granted index always comes with a done status.
    a_grant_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.granted_index != '0) |-> (o_rsp.status == fflia_pkg::ST_DONE))
        else $error("granted index with an error status");

    // The held count never exceeds the number of indices.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_rsp.in_use_count <= MAX_IDX))
        else $error("in-use count above the index range");

endmodule

`default_nettype wire
